@@ hdl/v3n_pkg.sv @@
// Shared widths, transaction types and helper functions for the vector normalizer.
package v3n_pkg;

	localparam int COMP_W = 32;
	localparam int FRAC_W = 16;
	localparam int CFG_W = 32;
	localparam int SUM_W = 2 * COMP_W;
	localparam int REM_W = COMP_W + 3;
	localparam int DREM_W = COMP_W + 2;
	localparam int Q_W = FRAC_W + 1;
	localparam int SQRT_CELLS = COMP_W;
	localparam int DIV_CELLS = FRAC_W + 1;
	localparam int XW = ((Q_W > COMP_W) ? Q_W : COMP_W) + 1;
	localparam int CMP_W = ((COMP_W > CFG_W) ? COMP_W : CFG_W);

	typedef struct packed {
		logic signed [COMP_W-1:0] in_x;
		logic signed [COMP_W-1:0] in_y;
		logic signed [COMP_W-1:0] in_z;
		logic signed [COMP_W-1:0] in_w;
	} vec_in_t;

	typedef struct packed {
		logic signed [COMP_W-1:0] out_x;
		logic signed [COMP_W-1:0] out_y;
		logic signed [COMP_W-1:0] out_z;
		logic signed [COMP_W-1:0] out_w;
		logic too_small;
	} vec_out_t;

	typedef struct packed {
		logic valid;
		logic [SUM_W-1:0] v;
		logic [REM_W-1:0] rem;
		logic [COMP_W-1:0] root;
		vec_in_t vec;
	} sqrt_stage_t;

	typedef struct packed {
		logic valid;
		logic low_mag;
		logic [COMP_W-1:0] mag;
		logic [2:0][DREM_W-1:0] rem;
		logic [2:0][Q_W-1:0] q;
		logic [2:0] neg;
		vec_in_t vec;
	} div_stage_t;

	function automatic logic [COMP_W-1:0] abs_comp(input logic [COMP_W-1:0] raw);
		return raw[COMP_W-1] ? (~raw + COMP_W'(1)) : raw;
	endfunction

	function automatic logic [COMP_W-1:0] sat_comp(input logic neg, input logic [Q_W-1:0] q);
		logic [XW-1:0] qx;
		logic [XW-1:0] lim;
		qx = XW'(q);
		if (neg) begin
			lim = XW'(1) << (COMP_W - 1);
			if (qx > lim) qx = lim;
			return COMP_W'(~qx + XW'(1));
		end
		lim = (XW'(1) << (COMP_W - 1)) - XW'(1);
		if (qx > lim) qx = lim;
		return COMP_W'(qx);
	endfunction

endpackage

@@ hdl/vector3_normalize_unit.sv @@
// Top level of the vector normalizer: squares, square root chain, divider chain.
//
//  channel | direction | handshake          | payload
//  vec     | in        | vec_valid/vec_stall | vec_in_t
//  res     | out       | res_valid/res_stall | vec_out_t
//  cfg     | in        | cfg_valid/cfg_ready | min_magnitude, 32 bits
//
// One transaction enters per cycle unless vec_stall is high; the path has
// 32 square root cells and 17 divider cells plus five registers by default.
// The whole pipeline advances together when the output register is empty or taken.
// A stalled output freezes every stage and raises vec_stall.
// Reset empties the pipeline and sets min_magnitude to 1; cfg_ready is always high.
module vector3_normalize_unit import v3n_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             vec_valid,
	output logic             vec_stall,
	input  vec_in_t          vec,
	output logic             res_valid,
	input  logic             res_stall,
	output vec_out_t         res,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [CFG_W-1:0] cfg_data
);
	logic             en;
	logic [CFG_W-1:0] min_mag_q;

	logic             valid_s1;
	vec_in_t          vec_s1;
	logic [2:0][COMP_W-1:0] abs_s1;
	logic             valid_s2;
	vec_in_t          vec_s2;
	logic [2:0][SUM_W-1:0]  sq_s2;

	sqrt_stage_t sq_chain [SQRT_CELLS+1];
	div_stage_t  dv_chain [DIV_CELLS+1];
	div_stage_t  dv_init;
	logic        low_mag;
	vec_out_t    res_q;
	logic        res_valid_q;

	assign en = !res_valid_q || !res_stall;
	assign vec_stall = !en;
	assign cfg_ready = 1'b1;
	assign res_valid = res_valid_q;
	assign res = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_mag_q <= CFG_W'(1);
		end else if (cfg_valid) begin
			min_mag_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			res_valid_q <= 1'b0;
		end else if (en) begin
			valid_s1 <= vec_valid;
			valid_s2 <= valid_s1;
			res_valid_q <= dv_chain[DIV_CELLS].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vec_s1 <= vec;
			abs_s1[0] <= abs_comp(vec.in_x);
			abs_s1[1] <= abs_comp(vec.in_y);
			abs_s1[2] <= abs_comp(vec.in_z);
			vec_s2 <= vec_s1;
			for (int k = 0; k < 3; k++) begin
				sq_s2[k] <= SUM_W'(abs_s1[k]) * SUM_W'(abs_s1[k]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_chain[0] <= '0;
		end else if (en) begin
			sq_chain[0].valid <= valid_s2;
			sq_chain[0].v <= sq_s2[0] + sq_s2[1] + sq_s2[2];
			sq_chain[0].rem <= '0;
			sq_chain[0].root <= '0;
			sq_chain[0].vec <= vec_s2;
		end
	end

	for (genvar i = 0; i < SQRT_CELLS; i++) begin : g_sqrt
		v3n_sqrt_cell u_cell (
			.clk(clk), .arst_n(arst_n), .en(en), .d(sq_chain[i]), .q(sq_chain[i+1])
		);
	end

	always_comb begin
		low_mag = (sq_chain[SQRT_CELLS].root == '0) ||
			(CMP_W'(sq_chain[SQRT_CELLS].root) < CMP_W'(min_mag_q));
		dv_init.valid = sq_chain[SQRT_CELLS].valid;
		dv_init.low_mag = low_mag;
		dv_init.mag = sq_chain[SQRT_CELLS].root;
		dv_init.vec = sq_chain[SQRT_CELLS].vec;
		dv_init.q = '0;
		dv_init.neg = {sq_chain[SQRT_CELLS].vec.in_z[COMP_W-1],
			sq_chain[SQRT_CELLS].vec.in_y[COMP_W-1],
			sq_chain[SQRT_CELLS].vec.in_x[COMP_W-1]};
		dv_init.rem[0] = DREM_W'(abs_comp(sq_chain[SQRT_CELLS].vec.in_x));
		dv_init.rem[1] = DREM_W'(abs_comp(sq_chain[SQRT_CELLS].vec.in_y));
		dv_init.rem[2] = DREM_W'(abs_comp(sq_chain[SQRT_CELLS].vec.in_z));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_chain[0] <= '0;
		end else if (en) begin
			dv_chain[0] <= dv_init;
		end
	end

	for (genvar j = 0; j < DIV_CELLS; j++) begin : g_div
		v3n_div_cell u_cell (
			.clk(clk), .arst_n(arst_n), .en(en), .d(dv_chain[j]), .q(dv_chain[j+1])
		);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_q.out_w <= dv_chain[DIV_CELLS].vec.in_w;
			res_q.too_small <= dv_chain[DIV_CELLS].low_mag;
			if (dv_chain[DIV_CELLS].low_mag) begin
				res_q.out_x <= dv_chain[DIV_CELLS].vec.in_x;
				res_q.out_y <= dv_chain[DIV_CELLS].vec.in_y;
				res_q.out_z <= dv_chain[DIV_CELLS].vec.in_z;
			end else begin
				res_q.out_x <= sat_comp(dv_chain[DIV_CELLS].neg[0], dv_chain[DIV_CELLS].q[0]);
				res_q.out_y <= sat_comp(dv_chain[DIV_CELLS].neg[1], dv_chain[DIV_CELLS].q[1]);
				res_q.out_z <= sat_comp(dv_chain[DIV_CELLS].neg[2], dv_chain[DIV_CELLS].q[2]);
			end
		end
	end
endmodule

@@ hdl/v3n_sqrt_cell.sv @@
// One cell of the square root chain: resolves one root bit from two sum bits.
module v3n_sqrt_cell import v3n_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  sqrt_stage_t d,
	output sqrt_stage_t q
);
	logic [REM_W-1:0] rem_sh;
	logic [REM_W-1:0] trial;
	logic             ge;

	always_comb begin
		rem_sh = {d.rem[REM_W-3:0], d.v[SUM_W-1:SUM_W-2]};
		trial = REM_W'({d.root, 2'b01});
		ge = rem_sh >= trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q <= '0;
		end else if (en) begin
			q.valid <= d.valid;
			q.v <= {d.v[SUM_W-3:0], 2'b00};
			q.rem <= ge ? (rem_sh - trial) : rem_sh;
			q.root <= {d.root[COMP_W-2:0], ge};
			q.vec <= d.vec;
		end
	end
endmodule

@@ hdl/v3n_div_cell.sv @@
// One cell of the divider chain: one quotient bit for each of the three components.
module v3n_div_cell import v3n_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       en,
	input  div_stage_t d,
	output div_stage_t q
);
	logic [2:0][DREM_W-1:0] r1;
	logic [2:0]             ge;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			ge[k] = d.rem[k] >= DREM_W'(d.mag);
			r1[k] = ge[k] ? (d.rem[k] - DREM_W'(d.mag)) : d.rem[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q <= '0;
		end else if (en) begin
			q.valid <= d.valid;
			q.low_mag <= d.low_mag;
			q.mag <= d.mag;
			q.neg <= d.neg;
			q.vec <= d.vec;
			for (int k = 0; k < 3; k++) begin
				q.rem[k] <= {r1[k][DREM_W-2:0], 1'b0};
				q.q[k] <= {d.q[k][Q_W-2:0], ge[k]};
			end
		end
	end
endmodule

@@ hdl/v3n_checker.sv @@
// Port-level checks for the vector normalizer, bound to the top level.
module v3n_checker import v3n_pkg::*; (
	input logic     clk,
	input logic     arst_n,
	input logic     vec_stall,
	input logic     res_valid,
	input logic     res_stall,
	input vec_out_t res,
	input logic     cfg_ready
);
	localparam logic signed [COMP_W:0] One = (COMP_W+1)'(1) << FRAC_W;

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res))
		else $error("Result changed while stalled.");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		vec_stall |-> res_valid && res_stall)
		else $error("Input stalled without a stalled result.");

	a_unit_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.too_small && (FRAC_W + 1 < COMP_W) |->
		(COMP_W+1)'(res.out_x) <= One && (COMP_W+1)'(res.out_x) >= -One &&
		(COMP_W+1)'(res.out_y) <= One && (COMP_W+1)'(res.out_y) >= -One &&
		(COMP_W+1)'(res.out_z) <= One && (COMP_W+1)'(res.out_z) >= -One)
		else $error("Normalized component above one.");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n) cfg_ready)
		else $error("Configuration port not ready.");
endmodule

bind vector3_normalize_unit v3n_checker u_v3n_checker (
	.clk(clk), .arst_n(arst_n), .vec_stall(vec_stall),
	.res_valid(res_valid), .res_stall(res_stall), .res(res), .cfg_ready(cfg_ready)
);
